// ----- rtl/nsr_pkg.sv -----
// Shared constants and types for the Newton-Raphson square root block.
package nsr_pkg;

  // Fixed-point format and iteration limit
  localparam int FRAC_BITS  = 16;
  localparam int ITERATIONS = 6;

  // Field widths
  localparam int VALUE_W = 32;
  localparam int ROOT_W  = 31;
  localparam int TOL_W   = 16;
  localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(66);

  // Operand magnitude, dividend (x << FRAC_BITS) and guess widths
  localparam int X_W     = VALUE_W - 1;
  localparam int DVD_W   = X_W + FRAC_BITS;
  localparam int GUESS_W = DVD_W + 1;
  localparam int CNT_W   = $clog2(DVD_W);
  localparam int ITER_W  = (ITERATIONS > 1) ? $clog2(ITERATIONS) : 1;

  // Configuration port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic REG_TOLERANCE = 1'b0;  // register index, paddr[2]

  // Sequencer state codes
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_UPD  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  typedef logic [VALUE_W-1:0] value_t;
  typedef logic [ROOT_W-1:0]  root_t;

endpackage

// ----- rtl/nsr_value_if.sv -----
// Operand channel: valid/ready handshake carrying one signed Q16.16 value.
interface nsr_value_if
  import nsr_pkg::*;
;
  logic   valid;
  logic   ready;
  value_t value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

// ----- rtl/nsr_root_if.sv -----
// Result channel: valid/ready handshake carrying one unsigned Q15.16 root.
interface nsr_root_if
  import nsr_pkg::*;
;
  logic  valid;
  logic  ready;
  root_t root;

  modport source (output valid, output root, input ready);
  modport sink   (input valid, input root, output ready);
endinterface

// ----- rtl/newton_square_root_top.sv -----
// Newton-Raphson square root of a signed Q16.16 operand, bit-serial divider.
//
// in_i carries one operand per transaction, out_o one Q15.16 root per
// operand, both valid/ready; a transaction completes when valid and ready
// are high at a rising edge. The APB port holds the tolerance register at
// address 0: iteration stops once the guess moves by less than it.
// Operands of zero or below give 0 and exactly 1.0 gives 1.0; other
// operands run up to 6 Newton steps. Each step is a restoring radix-2
// division that retires one quotient bit per cycle, then a Newton update.
// One operand is processed at a time: in_i.ready is high only while the
// sequencer is idle. The result sits in an output register, so the next
// operand is accepted while a finished result still waits on out_o; if the
// receiver stalls, the following result is held until the register frees.
// Reset (rst_ni low, asynchronous) empties the block and sets the
// tolerance to 66 (about 0.001).
module newton_square_root_top
  import nsr_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  nsr_value_if.sink          in_i,
  nsr_root_if.source         out_o,
  input  logic               psel_i,
  input  logic               penable_i,
  input  logic               pwrite_i,
  input  logic [PADDR_W-1:0] paddr_i,
  input  logic [PDATA_W-1:0] pwdata_i,
  output logic [PDATA_W-1:0] prdata_o,
  output logic               pready_o
);

  logic [1:0]         state_q, state_d;
  logic               out_valid_q, out_valid_d;
  logic [TOL_W-1:0]   tol_q, tol_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [ITER_W-1:0]  iter_q, iter_d;
  logic [X_W-1:0]     x_q, x_d;
  logic [DVD_W-1:0]   dvd_q, dvd_d;
  logic [GUESS_W-1:0] rem_q, rem_d;
  logic [DVD_W-1:0]   quo_q, quo_d;
  logic [GUESS_W-1:0] guess_q, guess_d;
  logic [ROOT_W-1:0]  res_q, res_d;
  logic [ROOT_W-1:0]  root_q, root_d;

  logic               in_fire;
  logic               cfg_wr;
  logic [X_W-1:0]     in_x;
  logic [GUESS_W-1:0] init_guess;
  logic [GUESS_W:0]   trial;
  logic [GUESS_W:0]   trial_sub;
  logic [GUESS_W:0]   sum;
  logic [GUESS_W-1:0] next_guess;
  logic [GUESS_W-1:0] diff;
  logic               stop;
  logic               slot_free;

  // Configuration port
  assign pready_o = 1'b1;
  assign cfg_wr   = psel_i & penable_i & pwrite_i & pready_o;
  assign prdata_o = (paddr_i[2] == REG_TOLERANCE) ? PDATA_W'(tol_q) : '0;

  // Handshakes
  assign in_i.ready  = (state_q == ST_IDLE);
  assign in_fire     = in_i.valid & in_i.ready;
  assign out_o.valid = out_valid_q;
  assign out_o.root  = root_q;
  assign slot_free   = ~out_valid_q | out_o.ready;

  // Starting guess: half the operand, at least one LSB
  assign in_x       = in_i.value[X_W-1:0];
  assign init_guess = (in_x[X_W-1:1] == '0) ? GUESS_W'(1) : GUESS_W'(in_x[X_W-1:1]);

  // Restoring division step: one quotient bit per cycle
  assign trial     = {rem_q, dvd_q[DVD_W-1]};
  assign trial_sub = trial - {1'b0, guess_q};

  // Newton update from the finished quotient
  assign sum        = {1'b0, guess_q} + (GUESS_W+1)'(quo_q);
  assign next_guess = (sum[GUESS_W:1] == '0) ? GUESS_W'(1) : sum[GUESS_W:1];
  assign diff       = (next_guess >= guess_q) ? (next_guess - guess_q)
                                              : (guess_q - next_guess);
  assign stop       = (diff < GUESS_W'(tol_q)) || (iter_q == ITER_W'(ITERATIONS - 1));

  // Sequencer and datapath next state
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    tol_d       = tol_q;
    cnt_d       = cnt_q;
    iter_d      = iter_q;
    x_d         = x_q;
    dvd_d       = dvd_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    guess_d     = guess_q;
    res_d       = res_q;
    root_d      = root_q;

    if (cfg_wr && (paddr_i[2] == REG_TOLERANCE)) begin
      tol_d = pwdata_i[TOL_W-1:0];
    end

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          x_d     = in_x;
          guess_d = init_guess;
          dvd_d   = {in_x, FRAC_BITS'(0)};
          rem_d   = '0;
          cnt_d   = CNT_W'(DVD_W - 1);
          iter_d  = '0;
          if (in_i.value[VALUE_W-1] || (in_i.value == '0)) begin
            res_d   = '0;
            state_d = ST_DONE;
          end else if (in_i.value == VALUE_W'(1 << FRAC_BITS)) begin
            res_d   = ROOT_W'(1 << FRAC_BITS);
            state_d = ST_DONE;
          end else begin
            state_d = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        dvd_d = {dvd_q[DVD_W-2:0], 1'b0};
        if (!trial_sub[GUESS_W]) begin
          rem_d = trial_sub[GUESS_W-1:0];
        end else begin
          rem_d = trial[GUESS_W-1:0];
        end
        quo_d = {quo_q[DVD_W-2:0], ~trial_sub[GUESS_W]};
        cnt_d = cnt_q - CNT_W'(1);
        if (cnt_q == '0) begin
          state_d = ST_UPD;
        end
      end
      ST_UPD: begin
        guess_d = next_guess;
        iter_d  = iter_q + ITER_W'(1);
        dvd_d   = {x_q, FRAC_BITS'(0)};
        rem_d   = '0;
        cnt_d   = CNT_W'(DVD_W - 1);
        // Saturate to the 31-bit output range
        res_d   = (next_guess[GUESS_W-1:ROOT_W] != '0) ? '1 : next_guess[ROOT_W-1:0];
        state_d = stop ? ST_DONE : ST_DIV;
      end
      ST_DONE: begin
        if (slot_free) begin
          root_d      = res_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      tol_q       <= TOL_RESET;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      tol_q       <= tol_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    cnt_q   <= cnt_d;
    iter_q  <= iter_d;
    x_q     <= x_d;
    dvd_q   <= dvd_d;
    rem_q   <= rem_d;
    quo_q   <= quo_d;
    guess_q <= guess_d;
    res_q   <= res_d;
    root_q  <= root_d;
  end

endmodule

// ----- rtl/nsr_checker.sv -----
// Port-level checks for the square root block, bound to the top level.
module nsr_checker
  import nsr_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [ROOT_W-1:0] out_root_i
);

  // A stalled result holds its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_root_i))
    else $error("stalled result changed or dropped");

  // Accepting an operand makes the block busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("operand accepted while a calculation is running");

  // A fresh result appears only as the block returns from busy to idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> in_ready_i && $past(!in_ready_i))
    else $error("result appeared outside completion of a calculation");

  // The block becomes idle only by handing over a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_ready_i) |-> out_valid_i)
    else $error("block went idle without a result");

endmodule

bind newton_square_root_top nsr_checker u_nsr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_root_i  (out_o.root)
);

// ----- dv/newton_square_root_top_tb.sv -----
// Testbench for newton_square_root_top: directed table plus checked random operands.
module newton_square_root_top_tb
  import nsr_pkg::*;
;

  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int          GAP_MAX     = 17;
  localparam int          DIR_N       = 12;
  localparam int          PHASE_N     = 8;
  localparam int          PHASE_ITEMS = 204;
  localparam logic [PADDR_W-1:0] TOL_ADDR = {REG_TOLERANCE, 2'b00};

  // One directed operand; root is typed in only where known is set
  typedef struct packed {
    value_t value;
    logic   known;
    root_t  root;
  } dir_row_t;

  localparam dir_row_t DIR_ROWS [DIR_N] = '{
    '{32'h0000_0000, 1'b1, 31'h0000_0000},  // zero
    '{32'h8000_0000, 1'b1, 31'h0000_0000},  // most negative
    '{32'hFFFF_FFFF, 1'b1, 31'h0000_0000},  // minus one LSB
    '{32'hFFFF_0000, 1'b1, 31'h0000_0000},  // minus 1.0
    '{32'h0001_0000, 1'b1, 31'h0001_0000},  // exactly 1.0
    '{32'h0000_0001, 1'b0, 31'h0000_0000},  // start guess forced to one LSB
    '{32'h0000_0002, 1'b0, 31'h0000_0000},
    '{32'h7FFF_FFFF, 1'b0, 31'h0000_0000},  // largest operand
    '{32'h0004_0000, 1'b0, 31'h0000_0000},  // 4.0
    '{32'h0000_FFFF, 1'b0, 31'h0000_0000},  // just under 1.0
    '{32'h0001_0001, 1'b0, 31'h0000_0000},  // just over 1.0
    '{32'h5555_5555, 1'b0, 31'h0000_0000}
  };

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  nsr_value_if value_if ();
  nsr_root_if  root_if ();

  newton_square_root_top dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (value_if),
    .out_o     (root_if),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .pready_o  (pready)
  );

  logic [TOL_W-1:0] tol_shadow;
  root_t            root_expected [$];
  int unsigned      err_cnt;
  int unsigned      cycle_cnt;
  int               sink_wait;
  bit               quiet_src;
  bit               quiet_sink;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Newton-Raphson root of a Q16.16 operand at the given tolerance
  function automatic root_t newton_root(value_t v, logic [TOL_W-1:0] tol);
    logic [63:0] x;
    logic [63:0] scaled;
    logic [63:0] guess;
    logic [63:0] next_g;
    logic [63:0] quot;
    logic [63:0] delta;
    bit          settled;
    int          step;
    if (v == '0 || v[VALUE_W-1]) return '0;
    x = 64'(v);
    if (x == (64'd1 << FRAC_BITS)) return ROOT_W'(x);
    scaled  = x << FRAC_BITS;
    guess   = x >> 1;
    settled = 1'b0;
    if (guess == 64'd0) guess = 64'd1;
    for (step = 0; step < ITERATIONS; step++) begin
      if (!settled) begin
        quot   = scaled / guess;
        next_g = (guess + quot) >> 1;
        if (next_g == 64'd0) next_g = 64'd1;
        delta  = (next_g >= guess) ? next_g - guess : guess - next_g;
        guess  = next_g;
        if (delta < 64'(tol)) settled = 1'b1;
      end
    end
    return (guess > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : ROOT_W'(guess);
  endfunction

  // Random operand, weighted toward positive and small values
  function automatic value_t rand_value();
    int unsigned pick;
    int unsigned n;
    pick = $urandom_range(0, 99);
    n    = $urandom_range(0, 46340);
    if (pick < 25) return value_t'($urandom());
    if (pick < 55) return {1'b0, 31'($urandom())};
    if (pick < 70) return value_t'($urandom_range(0, 32'h0002_0000));
    if (pick < 80) return value_t'($urandom_range(1, 255));
    if (pick < 88) return value_t'(32'h0000_FFFE + $urandom_range(0, 4));
    if (pick < 92) return (pick[0]) ? 32'h7FFF_FFFF : 32'h8000_0000;
    return value_t'(n * n);
  endfunction

  task automatic report_mismatch(string msg);
    $display("tb: mismatch at cycle %0d: %s", cycle_cnt, msg);
    err_cnt++;
  endtask

  // Called at a falling edge; returns at the falling edge after the transaction
  task automatic send_value(value_t v, root_t exp_root, int gap);
    if (gap > 0) begin
      value_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    value_if.valid <= 1'b1;
    value_if.value <= v;
    do @(posedge clk_i); while (!value_if.ready);
    root_expected.push_back(exp_root);
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    value_if.valid <= 1'b0;
    while (root_expected.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_tolerance(logic [TOL_W-1:0] tol);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= TOL_ADDR;
    pwdata  <= PDATA_W'(tol);
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    tol_shadow = tol;
  endtask

  task automatic check_tolerance();
    logic [PDATA_W-1:0] rd;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= TOL_ADDR;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    rd = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd !== PDATA_W'(tol_shadow))
      report_mismatch($sformatf("tolerance read %h, want %h", rd, tol_shadow));
  endtask

  // Receiver ready: hold low for the drawn number of cycles after each transaction
  always @(negedge clk_i) begin
    if (sink_wait > 0) begin
      root_if.ready <= 1'b0;
      sink_wait = sink_wait - 1;
    end else begin
      root_if.ready <= 1'b1;
    end
  end

  // Result checker
  always @(posedge clk_i) begin
    root_t want;
    if (rst_ni && root_if.valid && root_if.ready) begin
      if (root_expected.size() == 0) begin
        report_mismatch($sformatf("unexpected root %h", root_if.root));
      end else begin
        want = root_expected.pop_front();
        if (root_if.root !== want)
          report_mismatch($sformatf("root %h, want %h", root_if.root, want));
      end
      sink_wait = quiet_sink ? 0 : $urandom_range(0, GAP_MAX);
    end
  end

  // Run limit
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Stimulus
  initial begin
    int        pass;
    int        idx;
    int        phase;
    value_t    v;
    dir_row_t  row;
    logic [TOL_W-1:0] tol;
    err_cnt        = 0;
    cycle_cnt      = 0;
    quiet_src      = 1'b0;
    quiet_sink     = 1'b0;
    sink_wait      = $urandom_range(0, GAP_MAX);
    tol_shadow     = TOL_RESET;
    rst_ni         = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    value_if.valid = 1'b0;
    value_if.value = '0;
    root_if.ready  = 1'b0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    check_tolerance();

    // Directed table: once at the reset tolerance, once with early stop disabled
    for (pass = 0; pass < 2; pass++) begin
      if (pass == 1) begin
        write_tolerance('0);
        check_tolerance();
      end
      for (idx = 0; idx < DIR_N; idx++) begin
        row = DIR_ROWS[idx];
        send_value(row.value, row.known ? row.root : newton_root(row.value, tol_shadow),
                   $urandom_range(0, GAP_MAX));
      end
      wait_idle();
    end

    // Random phases, each at its own tolerance
    for (phase = 0; phase < PHASE_N; phase++) begin
      unique case (phase)
        0: tol = 16'hFFFF;
        1: tol = 16'd1;
        2: tol = 16'd0;
        3: tol = TOL_RESET;
        4: tol = TOL_W'($urandom_range(0, 2000));
        default: tol = TOL_W'($urandom());
      endcase
      write_tolerance(tol);
      check_tolerance();
      quiet_src  = (phase % 3 == 1);
      quiet_sink = (phase % 4 == 2);
      for (idx = 0; idx < PHASE_ITEMS; idx++) begin
        v = rand_value();
        send_value(v, newton_root(v, tol_shadow), quiet_src ? 0 : $urandom_range(0, GAP_MAX));
      end
      wait_idle();
    end

    repeat (20) @(negedge clk_i);
    if (err_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/nsr_pkg.sv
rtl/nsr_value_if.sv
rtl/nsr_root_if.sv
rtl/newton_square_root_top.sv
rtl/nsr_checker.sv
dv/newton_square_root_top_tb.sv
